@@ src/icp_pkg.sv @@
// Shared types, constants and character helpers of the infix to postfix converter.
`default_nettype none

package icp_pkg;

   localparam logic [7:0] OPEN_PAREN  = 8'h28;
   localparam logic [7:0] CLOSE_PAREN = 8'h29;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_UNMATCHED = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

   localparam logic REG_POP_ON_EQUAL = 1'b0;

   typedef enum logic [1:0] {
      CLS_ALNUM,
      CLS_CLOSE,
      CLS_OPEN,
      CLS_OPER
   } char_class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIT_CHAR,
      ST_CLOSE,
      ST_POP_OPER,
      ST_PUSH,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      SEL_CHAR,
      SEL_TOP,
      SEL_UNMATCHED,
      SEL_OVERFLOW
   } emit_sel_type;

   typedef struct packed {
      logic         ready;
      logic         latch;
      logic         pop;
      logic         push;
      logic         emit;
      emit_sel_type sel;
      logic         finish;
   } cmd_type;

   typedef struct packed {
      logic           req_valid;
      char_class_type req_cls;
      logic           end_flag;
      logic           count_zero;
      logic           count_full;
      logic           top_is_open;
      logic           pop_ok;
      logic           out_free;
   } status_type;

   function automatic logic [1:0] precedence(input logic [7:0] c);
      logic [1:0] p;
      case (c)
         8'h2b, 8'h2d: p = 2'd1;
         8'h2a, 8'h2f: p = 2'd2;
         8'h5e:        p = 2'd3;
         default:      p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type k;
      if (c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39]}) begin
         k = CLS_ALNUM;
      end else if (c == CLOSE_PAREN) begin
         k = CLS_CLOSE;
      end else if (c == OPEN_PAREN) begin
         k = CLS_OPEN;
      end else begin
         k = CLS_OPER;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

@@ src/icp_req_if.sv @@
// Request channel interface: one infix character and its end-of-expression flag.
`default_nettype none

interface icp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_expr;

   modport source (output valid, output in_char, output end_of_expr, input ready);
   modport sink (input valid, input in_char, input end_of_expr, output ready);
endinterface

`default_nettype wire

@@ src/icp_rsp_if.sv @@
// Result channel interface: one postfix character or marker per request result.
`default_nettype none

interface icp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       char_valid;
   logic [1:0] error_code;
   logic       last;

   modport source (output valid, output out_char, output char_valid, output error_code,
                   output last, input ready);
   modport sink (input valid, input out_char, input char_valid, input error_code,
                 input last, output ready);
endinterface

`default_nettype wire

@@ src/icp_ctrl.sv @@
// Sequencer that steps the operator stack datapath through one request at a time.
`default_nettype none

module icp_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire icp_pkg::status_type st,
   output icp_pkg::cmd_type        cmd
);

   icp_pkg::state_type state_ff;
   icp_pkg::state_type state_in;
   icp_pkg::state_type after_body;

   function automatic icp_pkg::state_type class_state(input icp_pkg::char_class_type k);
      icp_pkg::state_type s;
      case (k)
         icp_pkg::CLS_ALNUM: s = icp_pkg::ST_EMIT_CHAR;
         icp_pkg::CLS_CLOSE: s = icp_pkg::ST_CLOSE;
         icp_pkg::CLS_OPEN:  s = icp_pkg::ST_PUSH;
         default:            s = icp_pkg::ST_POP_OPER;
      endcase
      return s;
   endfunction

   assign after_body = st.end_flag ? icp_pkg::ST_FLUSH : icp_pkg::ST_FINISH;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= icp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         icp_pkg::ST_IDLE: begin
            if (st.req_valid) state_in = class_state(st.req_cls);
         end
         icp_pkg::ST_EMIT_CHAR: begin
            if (st.out_free) state_in = after_body;
         end
         icp_pkg::ST_CLOSE: begin
            if (st.out_free && (st.count_zero || st.top_is_open)) state_in = after_body;
         end
         icp_pkg::ST_POP_OPER: begin
            if (st.out_free && !st.pop_ok) state_in = icp_pkg::ST_PUSH;
         end
         icp_pkg::ST_PUSH: begin
            if (st.out_free) state_in = after_body;
         end
         icp_pkg::ST_FLUSH: begin
            if (st.out_free && st.count_zero) state_in = icp_pkg::ST_FINISH;
         end
         icp_pkg::ST_FINISH: begin
            if (st.out_free) begin
               state_in = st.req_valid ? class_state(st.req_cls) : icp_pkg::ST_IDLE;
            end
         end
         default: state_in = icp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.sel = icp_pkg::SEL_CHAR;
      case (state_ff)
         icp_pkg::ST_IDLE: begin
            cmd.ready = 1'b1;
            cmd.latch = st.req_valid;
         end
         icp_pkg::ST_EMIT_CHAR: begin
            cmd.emit = st.out_free;
         end
         icp_pkg::ST_CLOSE: begin
            if (st.out_free) begin
               if (st.count_zero) begin
                  cmd.emit = 1'b1;
                  cmd.sel  = icp_pkg::SEL_UNMATCHED;
               end else begin
                  cmd.pop  = 1'b1;
                  cmd.emit = !st.top_is_open;
                  cmd.sel  = icp_pkg::SEL_TOP;
               end
            end
         end
         icp_pkg::ST_POP_OPER: begin
            if (st.out_free && st.pop_ok) begin
               cmd.pop  = 1'b1;
               cmd.emit = 1'b1;
               cmd.sel  = icp_pkg::SEL_TOP;
            end
         end
         icp_pkg::ST_PUSH: begin
            if (st.out_free) begin
               if (st.count_full) begin
                  cmd.emit = 1'b1;
                  cmd.sel  = icp_pkg::SEL_OVERFLOW;
               end else begin
                  cmd.push = 1'b1;
               end
            end
         end
         icp_pkg::ST_FLUSH: begin
            if (st.out_free && !st.count_zero) begin
               cmd.pop  = 1'b1;
               cmd.emit = !st.top_is_open;
               cmd.sel  = icp_pkg::SEL_TOP;
            end
         end
         icp_pkg::ST_FINISH: begin
            if (st.out_free) begin
               cmd.finish = 1'b1;
               cmd.ready  = 1'b1;
               cmd.latch  = st.req_valid;
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ src/icp_datapath.sv @@
// Operator stack memory, held request, pending result and output register of the converter.
`default_nettype none

module icp_datapath #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire icp_pkg::cmd_type cmd,
   input  wire logic             pop_on_equal,
   input  wire logic             req_valid,
   input  wire logic [7:0]       req_in_char,
   input  wire logic             req_end_of_expr,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_char_valid,
   output logic [1:0]            rsp_error_code,
   output logic                  rsp_last,
   output icp_pkg::status_type   st
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);

   logic [7:0]       stack_mem [STACK_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_cnt;
   logic [7:0]       top_ff, nxt_ff;
   logic [7:0]       char_ff;
   logic             end_ff;
   logic [1:0]       pc_ff;
   logic [1:0]       pt;

   logic [7:0]       pend_char_ff;
   logic             pend_valid_ff;
   logic [1:0]       pend_err_ff;
   logic             pend_full_ff;

   logic             rsp_vld_ff;
   logic [7:0]       rsp_char_ff;
   logic             rsp_cv_ff;
   logic [1:0]       rsp_err_ff;
   logic             rsp_last_ff;
   logic             out_load;

   logic [7:0]       sel_char;
   logic             sel_valid;
   logic [1:0]       sel_err;

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign rd_cnt = count_in - CNT_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // The top entry is cached in a register and the entry below it is prefetched,
   // so one pop completes every cycle while the output register has room.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[count_ff[IDX_W-1:0]] <= char_ff;
      end
      if (count_in >= CNT_W'(2)) begin
         nxt_ff <= stack_mem[rd_cnt[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         top_ff <= char_ff;
      end else if (cmd.pop) begin
         top_ff <= nxt_ff;
      end
      if (cmd.latch) begin
         char_ff <= req_in_char;
         end_ff  <= req_end_of_expr;
         pc_ff   <= icp_pkg::precedence(req_in_char);
      end
   end

   always_comb begin
      case (cmd.sel)
         icp_pkg::SEL_CHAR: begin
            sel_char  = char_ff;
            sel_valid = 1'b1;
            sel_err   = icp_pkg::ERR_NONE;
         end
         icp_pkg::SEL_TOP: begin
            sel_char  = top_ff;
            sel_valid = 1'b1;
            sel_err   = icp_pkg::ERR_NONE;
         end
         icp_pkg::SEL_UNMATCHED: begin
            sel_char  = 8'h00;
            sel_valid = 1'b0;
            sel_err   = icp_pkg::ERR_UNMATCHED;
         end
         default: begin
            sel_char  = 8'h00;
            sel_valid = 1'b0;
            sel_err   = icp_pkg::ERR_OVERFLOW;
         end
      endcase
   end

   // A result waits in the pending stage until the next one arrives or the
   // request finishes, so the final result of a request can be marked last.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_full_ff <= 1'b0;
      end else if (cmd.emit) begin
         pend_full_ff <= 1'b1;
      end else if (cmd.finish) begin
         pend_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         pend_char_ff  <= sel_char;
         pend_valid_ff <= sel_valid;
         pend_err_ff   <= sel_err;
      end
   end

   assign out_load = (cmd.emit && pend_full_ff) || cmd.finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (pend_full_ff) begin
            rsp_char_ff <= pend_char_ff;
            rsp_cv_ff   <= pend_valid_ff;
            rsp_err_ff  <= pend_err_ff;
         end else begin
            rsp_char_ff <= 8'h00;
            rsp_cv_ff   <= 1'b0;
            rsp_err_ff  <= icp_pkg::ERR_NONE;
         end
         rsp_last_ff <= cmd.finish;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_out_char   = rsp_char_ff;
   assign rsp_char_valid = rsp_cv_ff;
   assign rsp_error_code = rsp_err_ff;
   assign rsp_last       = rsp_last_ff;

   assign pt = icp_pkg::precedence(top_ff);

   always_comb begin
      st.req_valid   = req_valid;
      st.req_cls     = icp_pkg::classify(req_in_char);
      st.end_flag    = end_ff;
      st.count_zero  = (count_ff == '0);
      st.count_full  = (count_ff == CNT_W'(STACK_DEPTH));
      st.top_is_open = (top_ff == icp_pkg::OPEN_PAREN);
      st.pop_ok      = (count_ff != '0) && (top_ff != icp_pkg::OPEN_PAREN) &&
                       ((pt > pc_ff) || ((pt == pc_ff) && pop_on_equal));
      st.out_free    = !rsp_vld_ff || rsp_ready;
   end

endmodule

`default_nettype wire

@@ src/infix_to_postfix_converter_core.sv @@
// Top level of the shunting-yard infix to postfix converter.
// The req channel takes one character of an infix expression per request, with
// end_of_expr set on the last character. The rsp channel returns the postfix
// characters the request causes, in order; the final result of each request has
// last set. A request with nothing to emit returns one bare marker result, and an
// unmatched ')' or a push onto a full stack yields a marker with error_code set.
// Requests are worked one at a time by a sequencer over a stack memory of
// STACK_DEPTH entries with a cached top entry, popping one entry per cycle while
// the output register has room. A ')' pops operators up to its '('; any other
// operator pops those it yields to, then is pushed; end_of_expr adds a flush
// that pops every stacked entry. Results leave through an output register; a
// stall on rsp holds the sequencer while that register is full, and no result is
// dropped. Reset empties the stack, clears the output register and sets
// pop_on_equal to 1; no clearing pass runs. pop_on_equal lives at csr byte
// address 0. The user must write it only while idle; the block never checks.
`default_nettype none

module infix_to_postfix_converter_core #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   icp_req_if.sink          req_chan,
   icp_rsp_if.source        rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   icp_pkg::cmd_type    cmd;
   icp_pkg::status_type st;
   logic                pop_on_equal_ff;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_on_equal_ff <= 1'b1;
      end else if (csr_write && (csr_paddr[2] == icp_pkg::REG_POP_ON_EQUAL)) begin
         pop_on_equal_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == icp_pkg::REG_POP_ON_EQUAL) ?
                       {31'b0, pop_on_equal_ff} : 32'b0;

   icp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   icp_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .pop_on_equal    (pop_on_equal_ff),
      .req_valid       (req_chan.valid),
      .req_in_char     (req_chan.in_char),
      .req_end_of_expr (req_chan.end_of_expr),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_out_char    (rsp_chan.out_char),
      .rsp_char_valid  (rsp_chan.char_valid),
      .rsp_error_code  (rsp_chan.error_code),
      .rsp_last        (rsp_chan.last),
      .st              (st)
   );

   assign req_chan.ready = cmd.ready;

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !st.count_full)
      else $error("Push issued onto a full operator stack.");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.finish) |-> st.out_free)
      else $error("Result produced while the output register was occupied.");

   a_no_push_and_pop: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.pop))
      else $error("Push and pop issued in the same cycle.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |=> !req_chan.ready)
      else $error("New request taken while the previous one is still in work.");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench that streams infix characters and checks every postfix result.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STACK_DEPTH = 32;
   localparam logic [2:0]  POE_ADDR    = {icp_pkg::REG_POP_ON_EQUAL, 2'b00};

   typedef struct packed {
      logic [7:0] ch;
      logic       vld;
      logic [1:0] err;
      logic       fin;
   } postfix_item_type;

   class postfix_scoreboard;
      logic [7:0]       op_stack [STACK_DEPTH];
      int unsigned      depth_now;
      bit               pop_equal;
      postfix_item_type postfix_q[$];
      postfix_item_type fresh[$];
      int unsigned      mismatches;
      int unsigned      requests;
      int unsigned      results;
      int unsigned      unmatched_seen;
      int unsigned      overflow_seen;
      int unsigned      deepest;

      function new();
         depth_now      = 0;
         pop_equal      = 1'b1;
         mismatches     = 0;
         requests       = 0;
         results        = 0;
         unmatched_seen = 0;
         overflow_seen  = 0;
         deepest        = 0;
      endfunction

      function void set_pop_on_equal(bit v);
         pop_equal = v;
      endfunction

      function int unsigned pending();
         return postfix_q.size();
      endfunction

      function bit is_operand(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
      endfunction

      function logic [1:0] rank(logic [7:0] c);
         case (c)
            "+", "-": return 2'd1;
            "*", "/": return 2'd2;
            "^":      return 2'd3;
            default:  return 2'd0;
         endcase
      endfunction

      function void add(logic [7:0] c, logic v, logic [1:0] e);
         fresh.push_back('{ch: c, vld: v, err: e, fin: 1'b0});
      endfunction

      function void note_request(logic [7:0] c, logic e);
         logic [7:0] top;
         bit         matched;
         fresh.delete();
         requests++;
         if (is_operand(c)) begin
            add(c, 1'b1, icp_pkg::ERR_NONE);
         end else if (c == icp_pkg::CLOSE_PAREN) begin
            matched = 1'b0;
            while (depth_now > 0 && !matched) begin
               depth_now--;
               top = op_stack[depth_now];
               if (top == icp_pkg::OPEN_PAREN) begin
                  matched = 1'b1;
               end else begin
                  add(top, 1'b1, icp_pkg::ERR_NONE);
               end
            end
            if (!matched) begin
               add(8'h00, 1'b0, icp_pkg::ERR_UNMATCHED);
               unmatched_seen++;
            end
         end else begin
            if (c != icp_pkg::OPEN_PAREN) begin
               while (depth_now > 0 && op_stack[depth_now - 1] != icp_pkg::OPEN_PAREN &&
                      (rank(op_stack[depth_now - 1]) > rank(c) ||
                       (rank(op_stack[depth_now - 1]) == rank(c) && pop_equal))) begin
                  depth_now--;
                  add(op_stack[depth_now], 1'b1, icp_pkg::ERR_NONE);
               end
            end
            if (depth_now >= STACK_DEPTH) begin
               add(8'h00, 1'b0, icp_pkg::ERR_OVERFLOW);
               overflow_seen++;
            end else begin
               op_stack[depth_now] = c;
               depth_now++;
               if (depth_now > deepest) begin
                  deepest = depth_now;
               end
            end
         end
         if (e) begin
            while (depth_now > 0) begin
               depth_now--;
               if (op_stack[depth_now] != icp_pkg::OPEN_PAREN) begin
                  add(op_stack[depth_now], 1'b1, icp_pkg::ERR_NONE);
               end
            end
         end
         if (fresh.size() == 0) begin
            add(8'h00, 1'b0, icp_pkg::ERR_NONE);
         end
         fresh[fresh.size() - 1].fin = 1'b1;
         foreach (fresh[i]) begin
            postfix_q.push_back(fresh[i]);
         end
      endfunction

      function void check_result(postfix_item_type got);
         postfix_item_type want;
         results++;
         if (postfix_q.size() == 0) begin
            $error("result with no request pending: out_char %02h error_code %0d",
                   got.ch, got.err);
            mismatches++;
            return;
         end
         want = postfix_q.pop_front();
         if (got.ch !== want.ch) begin
            $error("out_char: expected %02h, actual %02h", want.ch, got.ch);
            mismatches++;
         end
         if (got.vld !== want.vld) begin
            $error("char_valid: expected %0b, actual %0b", want.vld, got.vld);
            mismatches++;
         end
         if (got.err !== want.err) begin
            $error("error_code: expected %0d, actual %0d", want.err, got.err);
            mismatches++;
         end
         if (got.fin !== want.fin) begin
            $error("last: expected %0b, actual %0b", want.fin, got.fin);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   icp_req_if req_bus ();
   icp_rsp_if rsp_bus ();

   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   postfix_scoreboard sb = new();
   bit                quiet = 1'b0;
   int unsigned       sent = 0;
   logic [7:0]        expr_chars[$];

   string operands  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
   string operators = "+-*/^";
   string odd_ops   = "=%&<>!?.,;";

   infix_to_postfix_converter_core #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         sb.check_result('{ch: rsp_bus.out_char, vld: rsp_bus.char_valid,
                           err: rsp_bus.error_code, fin: rsp_bus.last});
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic send_char(logic [7:0] c, logic e);
      req_bus.valid       <= 1'b1;
      req_bus.in_char     <= c;
      req_bus.end_of_expr <= e;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(c, e);
      sent++;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], i == s.len() - 1);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] addr, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == POE_ADDR) begin
         sb.set_pop_on_equal(value[0]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_operand();
      return operands[$urandom_range(0, operands.len() - 1)];
   endfunction

   function automatic logic [7:0] pick_operator();
      if ($urandom_range(0, 7) == 0) begin
         return odd_ops[$urandom_range(0, odd_ops.len() - 1)];
      end
      return operators[$urandom_range(0, operators.len() - 1)];
   endfunction

   task automatic build_wellformed();
      int unsigned terms;
      int unsigned open_cnt;
      int unsigned k;
      terms    = $urandom_range(1, 6);
      open_cnt = 0;
      for (int unsigned i = 0; i < terms; i++) begin
         k = (open_cnt < 4 && $urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
         repeat (k) expr_chars.push_back(icp_pkg::OPEN_PAREN);
         open_cnt += k;
         expr_chars.push_back(pick_operand());
         if (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
            k = $urandom_range(1, open_cnt);
            repeat (k) expr_chars.push_back(icp_pkg::CLOSE_PAREN);
            open_cnt -= k;
         end
         if (i < terms - 1) begin
            expr_chars.push_back(pick_operator());
         end
      end
      repeat (open_cnt) expr_chars.push_back(icp_pkg::CLOSE_PAREN);
   endtask

   task automatic build_deep();
      int unsigned n;
      n = $urandom_range(30, 36);
      repeat (n) begin
         expr_chars.push_back(($urandom_range(0, 3) != 0) ? icp_pkg::OPEN_PAREN :
                              pick_operator());
      end
      expr_chars.push_back(pick_operand());
   endtask

   task automatic play_expression(bit noisy);
      logic e;
      for (int i = 0; i < expr_chars.size(); i++) begin
         e = noisy ? logic'($urandom_range(0, 1)) : (i == expr_chars.size() - 1);
         send_char(expr_chars[i], e);
      end
   endtask

   task automatic run_phase(int unsigned target, bit with_pause);
      int unsigned start_cnt;
      int unsigned pick;
      int unsigned idx;
      bit          first;
      bit          paused;
      start_cnt = sent;
      first     = 1'b1;
      paused    = 1'b0;
      while (sent - start_cnt < target) begin
         expr_chars.delete();
         pick  = first ? 65 : $urandom_range(0, 99);
         first = 1'b0;
         if (pick < 60) begin
            build_wellformed();
            play_expression(1'b0);
         end else if (pick < 72) begin
            build_deep();
            play_expression(1'b0);
         end else if (pick < 86) begin
            build_wellformed();
            idx = $urandom_range(0, expr_chars.size() - 1);
            expr_chars[idx] = ($urandom_range(0, 1) == 0) ? icp_pkg::CLOSE_PAREN :
                              8'($urandom_range(0, 255));
            play_expression(1'b0);
         end else begin
            repeat ($urandom_range(1, 8)) expr_chars.push_back(8'($urandom_range(0, 255)));
            play_expression(1'b1);
         end
         if (with_pause && !paused && sent - start_cnt >= target / 2) begin
            drain();
            paused = 1'b1;
         end
      end
      drain();
   endtask

   initial begin
      req_bus.valid       <= 1'b0;
      req_bus.in_char     <= 8'h00;
      req_bus.end_of_expr <= 1'b0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= 3'd0;
      csr_pwdata          <= 32'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("0+9*Z^z-A/a");
      send_text("(x-y)^z");
      send_text(")");
      send_text("a+b)");
      send_char(8'h00, 1'b0);
      send_char(8'hff, 1'b1);
      drain();

      write_csr(POE_ADDR, {31'($urandom_range(0, 32'h7fff_ffff)), 1'b0});
      run_phase(120, 1'b0);
      write_csr(POE_ADDR, {31'($urandom_range(0, 32'h7fff_ffff)), 1'b1});
      run_phase(120, 1'b1);
      write_csr(POE_ADDR, 32'd0);
      quiet = 1'b1;
      run_phase(115, 1'b0);
      repeat (10) @(posedge clock);

      $display("Run covered %0d requests and %0d results with pop_on_equal at 1, 0, 1 and 0.",
               sb.requests, sb.results);
      $display("It saw %0d unmatched closing parentheses, %0d overflows, stack depth up to %0d.",
               sb.unmatched_seen, sb.overflow_seen, sb.deepest);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
